// ===== rtl/afade_pkg.sv =====
// Package of shared constants, types and helpers for the ARGB linear fade block.
`default_nettype none

package afade_pkg;

   // Width of the internal time base; incoming time words are truncated or
   // zero-extended to it.
   localparam int TIME_WIDTH = 32;
   localparam int TIME_IN_W  = 32;
   localparam int COLOR_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = COLOR_W / CHAN_W;
   localparam int CH_IDX_W   = $clog2(NUM_CHAN);
   localparam int DUR_W      = 16;
   localparam int PROD_W     = CHAN_W + DUR_W;
   localparam int BIT_IDX_W  = $clog2(CHAN_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;

   // Item kinds carried on the request tuser.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FROM_COLOR    = 2'd0,
      REG_TO_COLOR      = 2'd1,
      REG_FADE_DURATION = 2'd2,
      REG_LOOP_ENABLE   = 2'd3
   } csr_idx_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EVAL  = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_PRE   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_STORE = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 capture;
      logic                 rec_start;
      logic                 fin_end;
      logic                 mul;
      logic                 pre;
      logic                 div;
      logic                 store;
      logic                 emit;
      logic [CH_IDX_W-1:0]  ch;
      logic [BIT_IDX_W-1:0] bit_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic kind;
      logic at_end;
   } status_type;

   // Channel ch of a packed colour, channel 0 being alpha in the top byte.
   function automatic logic [CHAN_W-1:0] chan_byte(input logic [COLOR_W-1:0] color,
                                                   input logic [CH_IDX_W-1:0] ch);
      chan_byte = color[COLOR_W-1-CHAN_W*ch -: CHAN_W];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/argb_linear_fade_core.sv =====
// Top level of the ARGB linear fade block: controller, datapath and result register.
//
// The block fades a packed ARGB colour linearly between two endpoints set by the
// configuration registers. Each request word carries a kind on req_tuser (start
// or tick) and the current time on req_tdata; each request produces exactly one
// response word holding the colour now held and the done flag.
// A start word and a tick at or past the end of the fade go straight from
// evaluation to the output. A tick inside the fade interpolates the four
// channels one after another through one 8 by 16 multiplier and one shared
// restoring divider that yields one quotient bit per cycle; each channel takes
// a multiply, a divider preload, one divide step per quotient bit and a store.
// The block works on one word at a time: req_tready rises again as the
// response is loaded into the output register.
// The response sits in an output register; a new request is taken while it
// waits, and the finished colour is held back until the receiver has taken the
// previous word, so nothing is lost when rsp_tready is held low.
// Synchronous reset clears the configuration and fade state (duration 1000 ticks) and
// empties the output register. Configuration writes must be made only while idle; the
// block does not enforce this. A write reloads the held colour with the start colour.
`default_nettype none

module argb_linear_fade_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration write port
   input  wire logic                             csr_wr_en,
   input  wire logic [afade_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [afade_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [31:0]                      req_tdata,  // [31:0] time_now
   input  wire logic                             req_tuser,  // [0] kind
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [31:0]                           rsp_tdata,  // [7:0] alpha_out,
                                                             // [15:8] red_out,
                                                             // [23:16] green_out,
                                                             // [31:24] blue_out
   output logic                                  rsp_tuser   // [0] done_flag
);
   import afade_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [COLOR_W-1:0] held_color;
   logic               finished;
   logic               slot_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff;
   logic               rsp_done_ff;

   // The output register is free when empty or being emptied this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   afade_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .slot_free  (slot_free),
      .status     (status),
      .cmd        (cmd)
   );

   afade_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_kind   (req_tuser),
      .req_time   (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .held_color (held_color),
      .finished   (finished)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Alpha leaves in the lowest byte, blue in the highest.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {chan_byte(held_color, 2'd3), chan_byte(held_color, 2'd2),
                         chan_byte(held_color, 2'd1), chan_byte(held_color, 2'd0)};
         rsp_done_ff <= finished;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   // A result is only moved into the output register when that does not
   // overwrite a word the receiver has not yet taken.
   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is being processed");

endmodule

`default_nettype wire

// ===== rtl/afade_ctrl.sv =====
// Controller state machine of the ARGB linear fade block.
`default_nettype none

module afade_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic                 slot_free,
   input  wire afade_pkg::status_type status,
   output afade_pkg::cmd_type        cmd
);
   import afade_pkg::*;

   state_type            state_ff, state_in;
   logic [CH_IDX_W-1:0]  ch_ff, ch_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      bit_in      = bit_ff;
      cmd         = '0;
      cmd.ch      = ch_ff;
      cmd.bit_idx = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.kind == KIND_START) begin
               cmd.rec_start = 1'b1;
               state_in      = S_EMIT;
            end else if (status.at_end) begin
               cmd.fin_end = 1'b1;
               state_in    = S_EMIT;
            end else begin
               ch_in    = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PRE;
         end
         S_PRE: begin
            cmd.pre  = 1'b1;
            bit_in   = BIT_IDX_W'(CHAN_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (bit_ff == '0) begin
               state_in = S_STORE;
            end else begin
               bit_in = bit_ff - BIT_IDX_W'(1);
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (ch_ff == CH_IDX_W'(NUM_CHAN - 1)) begin
               ch_in    = '0;
               state_in = S_EMIT;
            end else begin
               ch_in    = ch_ff + CH_IDX_W'(1);
               state_in = S_MUL;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         bit_ff   <= bit_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/afade_dp.sv =====
// Datapath of the ARGB linear fade block: registers, fade state, multiplier and serial divider.
`default_nettype none

module afade_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [afade_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [afade_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                             req_kind,
   input  wire logic [afade_pkg::TIME_IN_W-1:0]  req_time,
   input  wire afade_pkg::cmd_type               cmd,
   output afade_pkg::status_type                 status,
   output logic [afade_pkg::COLOR_W-1:0]         held_color,
   output logic                                  finished
);
   import afade_pkg::*;

   logic [COLOR_W-1:0]    from_ff, from_in;
   logic [COLOR_W-1:0]    to_ff, to_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic                  loop_ff, loop_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic                  swapped_ff, swapped_in;
   logic                  finished_ff, finished_in;
   logic [COLOR_W-1:0]    held_ff, held_in;

   logic                  kind_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [DUR_W-1:0]      elapsed_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [DUR_W-1:0]      rem_ff, rem_in;
   logic [CHAN_W-1:0]     quo_ff, quo_in;

   logic [COLOR_W-1:0]    src, dst;
   logic [CHAN_W-1:0]     chan_a, chan_b, mag, chan_val;
   logic                  rising;
   logic [TIME_WIDTH-1:0] elapsed;
   logic [DUR_W:0]        trial, trial_diff;
   logic                  fits;

   assign src     = swapped_ff ? to_ff : from_ff;
   assign dst     = swapped_ff ? from_ff : to_ff;
   assign chan_a  = chan_byte(src, cmd.ch);
   assign chan_b  = chan_byte(dst, cmd.ch);
   assign rising  = (chan_b >= chan_a);
   assign mag     = rising ? (chan_b - chan_a) : (chan_a - chan_b);
   assign elapsed = now_ff - start_ff;

   // One restoring division step: bring down the next product bit.
   assign trial      = {rem_ff, prod_ff[cmd.bit_idx]};
   assign fits       = (trial >= {1'b0, dur_ff});
   assign trial_diff = trial - {1'b0, dur_ff};

   // Falling channels round the step up so that they never undershoot.
   assign chan_val = rising ? (chan_a + quo_ff)
                            : (chan_a - (quo_ff + CHAN_W'(rem_ff != '0)));

   assign status     = '{kind: kind_ff, at_end: (elapsed >= TIME_WIDTH'(dur_ff))};
   assign held_color = held_ff;
   assign finished   = finished_ff;

   always_comb begin
      from_in     = from_ff;
      to_in       = to_ff;
      dur_in      = dur_ff;
      loop_in     = loop_ff;
      start_in    = start_ff;
      swapped_in  = swapped_ff;
      finished_in = finished_ff;
      held_in     = held_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;

      if (csr_wr_en) begin
         case (csr_index)
            REG_FROM_COLOR:    from_in = COLOR_W'(csr_wdata);
            REG_TO_COLOR:      to_in   = COLOR_W'(csr_wdata);
            REG_FADE_DURATION: dur_in  = csr_wdata[DUR_W-1:0];
            REG_LOOP_ENABLE:   loop_in = csr_wdata[0];
            default:           from_in = from_ff;
         endcase
         swapped_in  = 1'b0;
         finished_in = 1'b0;
         held_in     = from_in;
      end

      if (cmd.rec_start) begin
         start_in = now_ff;
      end

      if (cmd.fin_end) begin
         held_in = dst;
         if (loop_ff) begin
            swapped_in = ~swapped_ff;
            start_in   = now_ff;
         end else begin
            finished_in = 1'b1;
         end
      end

      if (cmd.pre) begin
         rem_in = prod_ff[PROD_W-1 -: DUR_W];
         quo_in = '0;
      end

      if (cmd.div) begin
         rem_in = fits ? trial_diff[DUR_W-1:0] : trial[DUR_W-1:0];
         quo_in = {quo_ff[CHAN_W-2:0], fits};
      end

      if (cmd.store) begin
         held_in[COLOR_W-1-CHAN_W*cmd.ch -: CHAN_W] = chan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         from_ff     <= '0;
         to_ff       <= '0;
         dur_ff      <= DUR_RESET;
         loop_ff     <= 1'b0;
         start_ff    <= '0;
         swapped_ff  <= 1'b0;
         finished_ff <= 1'b0;
         held_ff     <= '0;
      end else begin
         from_ff     <= from_in;
         to_ff       <= to_in;
         dur_ff      <= dur_in;
         loop_ff     <= loop_in;
         start_ff    <= start_in;
         swapped_ff  <= swapped_in;
         finished_ff <= finished_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         now_ff  <= TIME_WIDTH'(req_time);
      end
      if (cmd.rec_start || cmd.fin_end || status.at_end) begin
         elapsed_ff <= elapsed_ff;
      end else begin
         elapsed_ff <= elapsed[DUR_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mag) * PROD_W'(elapsed_ff);
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // The stop flag is only ever raised by a non-looping fade.
   a_finished_not_looping: assert property (@(posedge clock) disable iff (reset)
      !(finished_ff && loop_ff))
      else $error("finished flag set while looping is enabled");

   // The partial remainder stays below the divisor, so eight steps suffice.
   a_rem_below_dur: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> (rem_ff < dur_ff))
      else $error("divider remainder not below duration");

   // The channel step never exceeds the distance between the endpoints.
   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> ((CHAN_W + 1)'(quo_ff) + (CHAN_W + 1)'(rem_ff != '0)
                     <= (CHAN_W + 1)'(mag)))
      else $error("interpolation step larger than channel difference");

endmodule

`default_nettype wire
